>>> rtl/core/bom_pkg.sv
// Package for the billboard orientation matrix core: payload structs, codes,
// operand map and the sequencer program (step list and micro-op decode).
// No dependencies.
package bom_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int ProdW    = 64;
  localparam int AccW     = 66;
  localparam int DivW     = DataW + FracBits;
  localparam int NumRf    = 30;
  localparam int CntW     = $clog2(DivW + 1);

  // input commands
  localparam logic [2:0] CmdRow          = 3'd0;
  localparam logic [2:0] CmdOrigin       = 3'd1;
  localparam logic [2:0] CmdUp           = 3'd2;
  localparam logic [2:0] CmdCompute      = 3'd3;
  localparam logic [2:0] CmdComputeNoCam = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CfgMode   = 3'd0;
  localparam logic [2:0] CfgAxisX  = 3'd1;
  localparam logic [2:0] CfgAxisY  = 3'd2;
  localparam logic [2:0] CfgAxisZ  = 3'd3;
  localparam logic [2:0] CfgFwdOff = 3'd4;

  localparam logic [1:0] ModePoint = 2'd0;
  localparam logic [1:0] ModeAxis  = 2'd1;

  localparam logic [1:0] RowNone = 2'd3;

  // operand codes: below 32 the register file, 32 and above the named sources
  typedef logic [5:0] src_t;
  localparam src_t SrcOrg  = 6'd12;
  localparam src_t SrcCup  = 6'd15;
  localparam src_t SrcCam  = 6'd18;
  localparam src_t SrcRgt  = 6'd21;
  localparam src_t SrcUpv  = 6'd24;
  localparam src_t SrcFwd  = 6'd27;
  localparam src_t SrcAx0  = 6'd32;
  localparam src_t SrcAx1  = 6'd33;
  localparam src_t SrcAx2  = 6'd34;
  localparam src_t SrcFo   = 6'd35;
  localparam src_t SrcOne  = 6'd36;
  localparam src_t SrcTr0  = 6'd37;
  localparam src_t SrcTr1  = 6'd38;
  localparam src_t SrcTr2  = 6'd39;

  localparam logic [DataW-1:0] QOne = DataW'(1) << FracBits;

  typedef enum logic [2:0] {
    K_CAM, K_NORM, K_CROSS, K_MATV, K_TRANS
  } kind_e;

  typedef enum logic [2:0] {
    V_ORG, V_CUP, V_CAM, V_RGT, V_UPV, V_FWD, V_AX, V_TR
  } vec_e;

  typedef enum logic [1:0] {
    OP_MUL, OP_SQRT, OP_DIV
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FETCH_A, S_FETCH_B, S_MUL, S_MUL_WB,
    S_SQRT, S_DIV, S_DIV_WB, S_EMIT_RD, S_EMIT_OUT
  } state_e;

  typedef struct packed {
    op_e  op;
    src_t a;
    src_t b;
    src_t d;
    logic clr;
    logic neg;
    logic shf;
    logic st;
  } uop_t;

  typedef struct packed {
    kind_e kind;
    vec_e  va;
    vec_e  vb;
    vec_e  vd;
    logic  last;
  } step_t;

  typedef struct packed {
    logic [2:0]              command;
    logic [1:0]              row;
    logic signed [DataW-1:0] vec_x;
    logic signed [DataW-1:0] vec_y;
    logic signed [DataW-1:0] vec_z;
    logic signed [DataW-1:0] vec_w;
  } in_req_t;

  typedef struct packed {
    logic [1:0]              column;
    logic signed [DataW-1:0] out_x;
    logic signed [DataW-1:0] out_y;
    logic signed [DataW-1:0] out_z;
    logic                    degenerate;
    logic                    last;
  } out_rsp_t;

  function automatic logic [DataW-1:0] sat32(logic signed [AccW-1:0] v);
    if (v[AccW-1:DataW-1] == '0 || v[AccW-1:DataW-1] == '1) begin
      return v[DataW-1:0];
    end
    return v[AccW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
  endfunction

  function automatic src_t vsrc(vec_e v, logic [1:0] i);
    src_t base;
    case (v)
      V_ORG:   base = SrcOrg;
      V_CUP:   base = SrcCup;
      V_CAM:   base = SrcCam;
      V_RGT:   base = SrcRgt;
      V_UPV:   base = SrcUpv;
      V_FWD:   base = SrcFwd;
      V_AX:    base = SrcAx0;
      V_TR:    base = SrcTr0;
      default: base = SrcOrg;
    endcase
    return base + {4'b0000, i};
  endfunction

  // world element at row r, column c
  function automatic src_t wsrc(logic [1:0] r, logic [1:0] c);
    return {2'b00, r, c};
  endfunction

  function automatic logic [1:0] nx3(logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic [3:0] sub_last(kind_e k);
    logic [3:0] n;
    unique case (k)
      K_NORM:  n = 4'd6;
      K_MATV:  n = 4'd8;
      default: n = 4'd5;
    endcase
    return n;
  endfunction

  function automatic step_t mk(kind_e k, vec_e a, vec_e b, vec_e d, logic l);
    step_t s;
    s.kind = k;
    s.va   = a;
    s.vb   = b;
    s.vd   = d;
    s.last = l;
    return s;
  endfunction

  function automatic step_t prog_step(logic axis, logic [3:0] idx);
    step_t s;
    if (!axis) begin
      unique case (idx)
        4'd0:    s = mk(K_CAM,   V_CAM, V_CAM, V_CAM, 1'b0);
        4'd1:    s = mk(K_NORM,  V_CAM, V_CAM, V_CAM, 1'b0);
        4'd2:    s = mk(K_CROSS, V_CUP, V_CAM, V_RGT, 1'b0);
        4'd3:    s = mk(K_CROSS, V_CAM, V_RGT, V_UPV, 1'b0);
        default: s = mk(K_TRANS, V_CAM, V_CAM, V_TR,  1'b1);
      endcase
    end else begin
      unique case (idx)
        4'd0:    s = mk(K_CAM,   V_CAM, V_CAM, V_CAM, 1'b0);
        4'd1:    s = mk(K_NORM,  V_CAM, V_CAM, V_CAM, 1'b0);
        4'd2:    s = mk(K_NORM,  V_AX,  V_AX,  V_RGT, 1'b0);
        4'd3:    s = mk(K_MATV,  V_RGT, V_RGT, V_UPV, 1'b0);
        4'd4:    s = mk(K_NORM,  V_UPV, V_UPV, V_UPV, 1'b0);
        4'd5:    s = mk(K_CROSS, V_UPV, V_CAM, V_RGT, 1'b0);
        4'd6:    s = mk(K_NORM,  V_RGT, V_RGT, V_RGT, 1'b0);
        4'd7:    s = mk(K_CROSS, V_RGT, V_UPV, V_FWD, 1'b0);
        default: s = mk(K_TRANS, V_CAM, V_CAM, V_TR,  1'b1);
      endcase
    end
    return s;
  endfunction

  function automatic uop_t micro(step_t s, logic [3:0] sub);
    uop_t       u;
    logic [1:0] i;
    logic [1:0] j;
    logic [3:0] t;
    u.op  = OP_MUL;
    u.a   = SrcOne;
    u.b   = SrcOne;
    u.d   = SrcTr0;
    u.clr = 1'b0;
    u.neg = 1'b0;
    u.shf = 1'b1;
    u.st  = 1'b0;
    i     = sub[2:1];
    t     = sub - 4'd4;
    j     = t[1:0];
    case (s.kind)
      K_CAM: begin
        if (!sub[0]) begin
          u.a   = vsrc(V_ORG, i);
          u.clr = 1'b1;
        end else begin
          u.a   = wsrc(i, 2'd3);
          u.neg = 1'b1;
          u.st  = 1'b1;
          u.d   = vsrc(V_CAM, i);
        end
      end
      K_TRANS: begin
        if (!sub[0]) begin
          u.a   = wsrc(i, 2'd3);
          u.clr = 1'b1;
        end else begin
          u.a  = vsrc(V_CAM, i);
          u.b  = SrcFo;
          u.st = 1'b1;
          u.d  = vsrc(V_TR, i);
        end
      end
      K_NORM: begin
        if (sub < 4'd3) begin
          u.a   = vsrc(s.va, sub[1:0]);
          u.b   = vsrc(s.va, sub[1:0]);
          u.shf = 1'b0;
          u.clr = (sub == 4'd0);
        end else if (sub == 4'd3) begin
          u.op = OP_SQRT;
        end else begin
          u.op = OP_DIV;
          u.a  = vsrc(s.va, j);
          u.d  = vsrc(s.vd, j);
        end
      end
      K_CROSS: begin
        if (!sub[0]) begin
          u.a   = vsrc(s.va, nx3(i));
          u.b   = vsrc(s.vb, nx3(nx3(i)));
          u.clr = 1'b1;
        end else begin
          u.a   = vsrc(s.va, nx3(nx3(i)));
          u.b   = vsrc(s.vb, nx3(i));
          u.neg = 1'b1;
          u.st  = 1'b1;
          u.d   = vsrc(s.vd, i);
        end
      end
      K_MATV: begin
        i     = (sub < 4'd3) ? 2'd0 : ((sub < 4'd6) ? 2'd1 : 2'd2);
        t     = sub - ({1'b0, i, 1'b0} + {2'b00, i});
        j     = t[1:0];
        u.a   = wsrc(i, j);
        u.b   = vsrc(s.va, j);
        u.clr = (j == 2'd0);
        u.st  = (j == 2'd2);
        u.d   = vsrc(s.vd, i);
      end
      default: u.op = OP_MUL;
    endcase
    return u;
  endfunction

endpackage

>>> rtl/core/billboard_orientation_matrix_core.sv
// Billboard orientation matrix core: loads, sequencer, bit-serial multiply,
// square root and divide over one shared datapath. Depends on bom_pkg.
// A load is stored when it is accepted. A compute runs micro-ops one at a
// time on bit-serial units (multiply, square root, divide); a pass-through
// compute skips them and goes to readout. Each column is then read out and
// held until the output takes it.
// Throughput: one request at a time; input stalls until the last column goes.
// Reset clears control and configuration (axis to +y); stored vectors are not
// cleared and must be loaded before a compute.
module billboard_orientation_matrix_core
  import bom_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [DataW-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_req_t             in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_rsp_t            out_rsp_o
);

  state_e state_q, state_d;

  logic [1:0]       mode_q;
  logic [DataW-1:0] ax_q [3];
  logic [DataW-1:0] fo_q;

  logic [DataW-1:0] rf_q [NumRf];
  logic [DataW-1:0] tr_q [3];

  logic [3:0]      step_q;
  logic [3:0]      sub_q;
  logic [CntW-1:0] cnt_q;
  logic            axis_q;
  logic            pass_q;
  logic            deg_q;
  logic [1:0]      col_q;
  logic [1:0]      comp_q;

  logic [DataW-1:0]        opa_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] mcand_q;
  logic [DataW-1:0]        mplr_q;
  logic signed [AccW-1:0]  acc_q;
  logic [DataW-1:0]        len_q;
  logic [ProdW-1:0]        sqn_q;
  logic [DataW+1:0]        rem_q;
  logic [DataW-1:0]        root_q;
  logic [DivW-1:0]         num_q;
  logic [DataW-1:0]        drem_q;
  logic [DataW-1:0]        quo_q;
  logic                    dneg_q;
  out_rsp_t                out_q;

  step_t cur_step;
  uop_t  cur_uop;
  logic  sub_done;
  logic  in_acc, out_acc, is_compute, go_pass;

  src_t             rd_code;
  logic [DataW-1:0] rd_val;
  src_t             em_code;

  logic signed [ProdW-1:0] psh;
  logic signed [AccW-1:0]  acc_new;

  logic [DataW+3:0] rem_t, trial;
  logic             sq_ge;
  logic [DataW-1:0] root_new;
  logic [DataW:0]   drt;
  logic             d_ge;
  logic [DataW-1:0] mag;

  assign cur_step   = prog_step(axis_q, step_q);
  assign cur_uop    = micro(cur_step, sub_q);
  assign sub_done   = (sub_q == sub_last(cur_step.kind));
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_EMIT_OUT);
  assign out_acc    = out_valid_o && !out_stall_i;
  assign out_rsp_o  = out_q;
  assign is_compute = (in_req_i.command == CmdCompute) ||
                      (in_req_i.command == CmdComputeNoCam);
  assign go_pass    = (in_req_i.command == CmdComputeNoCam) || mode_q[1];

  // column source for readout
  always_comb begin
    if (pass_q) begin
      em_code = wsrc(comp_q, col_q);
    end else begin
      case (col_q)
        2'd0:    em_code = vsrc(V_RGT, comp_q);
        2'd1:    em_code = vsrc(V_UPV, comp_q);
        2'd2:    em_code = vsrc(axis_q ? V_FWD : V_CAM, comp_q);
        default: em_code = vsrc(V_TR, comp_q);
      endcase
    end
  end

  always_comb begin
    case (state_q)
      S_FETCH_B: rd_code = cur_uop.b;
      S_EMIT_RD: rd_code = em_code;
      default:   rd_code = cur_uop.a;
    endcase
  end

  always_comb begin
    if (!rd_code[5]) begin
      rd_val = rf_q[rd_code[4:0]];
    end else begin
      case (rd_code)
        SrcAx0:  rd_val = ax_q[0];
        SrcAx1:  rd_val = ax_q[1];
        SrcAx2:  rd_val = ax_q[2];
        SrcFo:   rd_val = fo_q;
        SrcOne:  rd_val = QOne;
        SrcTr0:  rd_val = tr_q[0];
        SrcTr1:  rd_val = tr_q[1];
        SrcTr2:  rd_val = tr_q[2];
        default: rd_val = '0;
      endcase
    end
  end

  // accumulate step of a multiply op
  always_comb begin
    psh     = cur_uop.shf ? (prod_q >>> FracBits) : prod_q;
    acc_new = (cur_uop.clr ? AccW'(0) : acc_q) +
              (cur_uop.neg ? -AccW'(psh) : AccW'(psh));
  end

  // one root bit per cycle
  always_comb begin
    rem_t    = {rem_q, sqn_q[ProdW-1:ProdW-2]};
    trial    = {2'b00, root_q, 2'b01};
    sq_ge    = (rem_t >= trial);
    root_new = {root_q[DataW-2:0], sq_ge};
  end

  // one quotient bit per cycle
  always_comb begin
    drt  = {drem_q, num_q[DivW-1]};
    d_ge = (drt >= {1'b0, len_q});
    mag  = rd_val[DataW-1] ? (~rd_val + DataW'(1)) : rd_val;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && is_compute) begin
          state_d = go_pass ? S_EMIT_RD : S_DECODE;
        end
      end
      S_DECODE:  state_d = (cur_uop.op == OP_SQRT) ? S_SQRT : S_FETCH_A;
      S_FETCH_A: begin
        if (cur_uop.op == OP_DIV) begin
          state_d = (len_q == '0) ? S_DIV_WB : S_DIV;
        end else begin
          state_d = S_FETCH_B;
        end
      end
      S_FETCH_B: state_d = S_MUL;
      S_MUL:     if (cnt_q == CntW'(DataW - 1)) state_d = S_MUL_WB;
      S_DIV:     if (cnt_q == CntW'(DivW - 1)) state_d = S_DIV_WB;
      S_SQRT: begin
        if (cnt_q == CntW'(DataW - 1)) begin
          state_d = (sub_done && cur_step.last) ? S_EMIT_RD : S_DECODE;
        end
      end
      S_MUL_WB, S_DIV_WB: begin
        state_d = (sub_done && cur_step.last) ? S_EMIT_RD : S_DECODE;
      end
      S_EMIT_RD:  if (comp_q == 2'd2) state_d = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (out_acc) state_d = (col_q == 2'd3) ? S_IDLE : S_EMIT_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModePoint;
      ax_q[0] <= '0;
      ax_q[1] <= QOne;
      ax_q[2] <= '0;
      fo_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMode:   mode_q  <= cfg_data_i[1:0];
        CfgAxisX:  ax_q[0] <= cfg_data_i;
        CfgAxisY:  ax_q[1] <= cfg_data_i;
        CfgAxisZ:  ax_q[2] <= cfg_data_i;
        CfgFwdOff: fo_q    <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      sub_q  <= '0;
      cnt_q  <= '0;
      axis_q <= 1'b0;
      pass_q <= 1'b0;
      deg_q  <= 1'b0;
      col_q  <= '0;
      comp_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc && is_compute) begin
            step_q <= '0;
            sub_q  <= '0;
            deg_q  <= 1'b0;
            col_q  <= '0;
            comp_q <= '0;
            axis_q <= (mode_q == ModeAxis);
            pass_q <= go_pass;
          end
        end
        S_DECODE, S_FETCH_A, S_FETCH_B: cnt_q <= '0;
        S_MUL, S_DIV: cnt_q <= cnt_q + CntW'(1);
        S_SQRT: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(DataW - 1)) begin
            if (root_new == '0) deg_q <= 1'b1;
            if (sub_done) begin
              sub_q  <= '0;
              step_q <= step_q + 4'd1;
            end else begin
              sub_q <= sub_q + 4'd1;
            end
          end
        end
        S_MUL_WB, S_DIV_WB: begin
          if (sub_done) begin
            sub_q  <= '0;
            step_q <= step_q + 4'd1;
          end else begin
            sub_q <= sub_q + 4'd1;
          end
        end
        S_EMIT_RD: comp_q <= comp_q + 2'd1;
        S_EMIT_OUT: begin
          if (out_acc) begin
            comp_q <= '0;
            col_q  <= col_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // stored vectors: loads and op results
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      case (in_req_i.command)
        CmdRow: begin
          if (in_req_i.row != RowNone) begin
            rf_q[{1'b0, in_req_i.row, 2'd0}] <= in_req_i.vec_x;
            rf_q[{1'b0, in_req_i.row, 2'd1}] <= in_req_i.vec_y;
            rf_q[{1'b0, in_req_i.row, 2'd2}] <= in_req_i.vec_z;
            rf_q[{1'b0, in_req_i.row, 2'd3}] <= in_req_i.vec_w;
          end
        end
        CmdOrigin: begin
          rf_q[SrcOrg[4:0]]        <= in_req_i.vec_x;
          rf_q[SrcOrg[4:0] + 5'd1] <= in_req_i.vec_y;
          rf_q[SrcOrg[4:0] + 5'd2] <= in_req_i.vec_z;
        end
        CmdUp: begin
          rf_q[SrcCup[4:0]]        <= in_req_i.vec_x;
          rf_q[SrcCup[4:0] + 5'd1] <= in_req_i.vec_y;
          rf_q[SrcCup[4:0] + 5'd2] <= in_req_i.vec_z;
        end
        default: ;
      endcase
    end else if ((state_q == S_MUL_WB && cur_uop.st) || state_q == S_DIV_WB) begin
      if (!cur_uop.d[5]) begin
        rf_q[cur_uop.d[4:0]] <= (state_q == S_MUL_WB) ? sat32(acc_new) :
                                (dneg_q ? (~quo_q + DataW'(1)) : quo_q);
      end else begin
        case (cur_uop.d)
          SrcTr0:  tr_q[0] <= sat32(acc_new);
          SrcTr1:  tr_q[1] <= sat32(acc_new);
          SrcTr2:  tr_q[2] <= sat32(acc_new);
          default: ;
        endcase
      end
    end
  end

  // serial arithmetic
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_DECODE: begin
        sqn_q  <= acc_q[ProdW-1:0];
        rem_q  <= '0;
        root_q <= '0;
      end
      S_FETCH_A: begin
        opa_q  <= rd_val;
        dneg_q <= rd_val[DataW-1];
        num_q  <= {mag, {FracBits{1'b0}}};
        drem_q <= '0;
        quo_q  <= '0;
      end
      S_FETCH_B: begin
        prod_q  <= '0;
        mcand_q <= ProdW'(signed'(opa_q));
        mplr_q  <= rd_val;
      end
      S_MUL: begin
        // sign bit of the multiplier carries negative weight
        if (mplr_q[0]) begin
          prod_q <= (cnt_q == CntW'(DataW - 1)) ? prod_q - mcand_q : prod_q + mcand_q;
        end
        mcand_q <= mcand_q <<< 1;
        mplr_q  <= mplr_q >> 1;
      end
      S_MUL_WB: acc_q <= acc_new;
      S_SQRT: begin
        rem_q  <= sq_ge ? 34'(rem_t - trial) : rem_t[DataW+1:0];
        root_q <= root_new;
        sqn_q  <= sqn_q << 2;
        if (cnt_q == CntW'(DataW - 1)) len_q <= root_new;
      end
      S_DIV: begin
        drem_q <= d_ge ? DataW'(drt - {1'b0, len_q}) : drt[DataW-1:0];
        quo_q  <= {quo_q[DataW-2:0], d_ge};
        num_q  <= num_q << 1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT_RD) begin
      out_q.column     <= col_q;
      out_q.degenerate <= pass_q ? 1'b0 : deg_q;
      out_q.last       <= (col_q == 2'd3);
      case (comp_q)
        2'd0:    out_q.out_x <= rd_val;
        2'd1:    out_q.out_y <= rd_val;
        default: out_q.out_z <= rd_val;
      endcase
    end
  end

  a_no_accept_while_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("request taken during readout");

  a_compute_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_compute) |=> in_stall_o) else $error("compute did not go busy");

  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (len_q != '0)) else $error("divide by zero length");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_rsp_o.last) |=> !out_valid_o) else $error("result after last");

endmodule
